FILE: rtl/core/skyki_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package skyki_pkg;

  // Keyframe table geometry.
  localparam int KF_NUM    = 8;
  localparam int KF_SLOTS  = 16;
  localparam int KF_SLOT_W = 4;

  // Time band in which the cloud tint is white.
  localparam logic [15:0] T_DAY_START = 16'd16384;
  localparam logic [15:0] T_DAY_END   = 16'd49152;
  localparam logic [15:0] T_HALF      = 16'h8000;

  // Camera height bounds for the fog scale (Q16.8 of 50.0 and 70.0).
  localparam logic signed [23:0] H_LO = 24'sd12800;
  localparam logic signed [23:0] H_HI = 24'sd17920;

  // Reciprocals for the constant divisions by 5, 25 and 125.
  localparam logic [18:0] RECIP5   = 19'd419431;
  localparam logic [28:0] RECIP25  = 29'd343597384;
  localparam logic [27:0] RECIP125 = 28'd137438954;

  // Rounding offsets of the fog distance divisions.
  localparam logic [43:0] FAR_BIAS  = 44'd819200;
  localparam logic [44:0] NEAR_BIAS = 45'd8192000;

  localparam logic [7:0]  INTEN_CAP = 8'd120;
  localparam logic [23:0] RGB_WHITE = 24'hFFFFFF;
  localparam logic [16:0] ONE_Q16   = 17'd65536;

  typedef struct packed {
    logic [15:0] day_ratio;
    logic [23:0] far_clip;
    logic signed [23:0] camera_height;
  } in_req_t;

  typedef struct packed {
    logic [23:0] base_color_rgb;
    logic [23:0] fog_color_rgb;
    logic [23:0] dome_color_rgb;
    logic [15:0] fog_distance;
    logic [23:0] fog_near;
    logic [23:0] fog_far;
    logic [15:0] cloud_alpha;
    logic [10:0] cloud_scale;
    logic [15:0] sky_alpha;
    logic [10:0] sky_scale;
    logic [2:0]  layer_keyframe;
    logic [23:0] cloud_tint_rgb;
  } out_req_t;

  typedef struct packed {
    logic [15:0] time_q;
    logic [23:0] base;
    logic [23:0] fog;
    logic        fog_from_reg;
    logic [23:0] dome;
    logic [15:0] fog_dist;
    logic [16:0] cloud_alpha;
    logic [10:0] cloud_scale;
    logic [16:0] sky_alpha;
    logic [10:0] sky_scale;
  } kf_t;

  // Item fields carried alongside the blend factor divider.
  typedef struct packed {
    kf_t         kf1;
    kf_t         kf2;
    logic [23:0] far_clip;
    logic [16:0] s_h;
    logic        day_band;
    logic [2:0]  layer;
  } carry_t;

  // Keyframe table; slots past the eighth read as zero.
  function automatic kf_t kf_rom(input logic [KF_SLOT_W-1:0] idx);
    kf_t k;
    k = '0;
    case (idx)
      4'd0: k = '{16'd0, 24'hFFFAEB, 24'h0, 1'b1, 24'hFFFFFF, 16'd3277,
                  17'd55255, 11'd256, 17'd65536, 11'd256};
      4'd1: k = '{16'd16384, 24'hFFFAEB, 24'h0, 1'b1, 24'hFFFFFF, 16'd3277,
                  17'd0, 11'd256, 17'd65536, 11'd256};
      4'd2: k = '{16'd19661, 24'hFFB9AA, 24'hAA4632, 1'b0, 24'hFFFFFF, 16'd13107,
                  17'd32768, 11'd256, 17'd32768, 11'd256};
      4'd3: k = '{16'd22938, 24'h6969C3, 24'h14143C, 1'b0, 24'h37379B, 16'd6554,
                  17'd65536, 11'd1024, 17'd0, 11'd256};
      4'd4: k = '{16'd32768, 24'h283CD2, 24'h050514, 1'b0, 24'h37379B, 16'd6554,
                  17'd65536, 11'd1024, 17'd55255, 11'd256};
      4'd5: k = '{16'd42598, 24'h283CD2, 24'h050514, 1'b0, 24'h37379B, 16'd6554,
                  17'd65536, 11'd1024, 17'd0, 11'd256};
      4'd6: k = '{16'd45875, 24'hBEA0FF, 24'h503C69, 1'b0, 24'hFFFFFF, 16'd32768,
                  17'd32768, 11'd256, 17'd32768, 11'd256};
      4'd7: k = '{16'd49152, 24'hFFFAEB, 24'h0, 1'b1, 24'hFFFFFF, 16'd13107,
                  17'd0, 11'd256, 17'd65536, 11'd256};
      default: k = '0;
    endcase
    return k;
  endfunction

  // Rounded linear blend: (a*(1-f) + b*f + 0.5) in Q16.
  function automatic logic [16:0] blend(input logic [16:0] a, input logic [16:0] b,
                                        input logic [15:0] f);
    logic signed [17:0] diff;
    logic signed [34:0] acc;
    diff = $signed({1'b0, b}) - $signed({1'b0, a});
    acc  = $signed({2'b00, a, 16'h0000}) + diff * $signed({1'b0, f}) + 35'sd32768;
    return acc[32:16];
  endfunction

  function automatic logic [7:0] blend8(input logic [7:0] a, input logic [7:0] b,
                                        input logic [15:0] f);
    logic [16:0] r;
    r = blend({9'd0, a}, {9'd0, b}, f);
    return r[7:0];
  endfunction

  function automatic logic [23:0] blend_rgb(input logic [23:0] a, input logic [23:0] b,
                                            input logic [15:0] f);
    return {blend8(a[23:16], b[23:16], f), blend8(a[15:8], b[15:8], f),
            blend8(a[7:0], b[7:0], f)};
  endfunction

  function automatic logic [15:0] sat16(input logic [16:0] v);
    return v[16] ? 16'hFFFF : v[15:0];
  endfunction

  // Two restoring division steps of the blend factor.
  function automatic logic [18:0] div_step2(input logic [16:0] rem, input logic [16:0] span);
    logic [17:0] r2;
    logic [16:0] r;
    logic [1:0]  q;
    r = rem;
    q = '0;
    for (int b = 1; b >= 0; b--) begin
      r2 = {r, 1'b0};
      if (r2 >= {1'b0, span}) begin
        r2   = r2 - {1'b0, span};
        q[b] = 1'b1;
      end
      r = r2[16:0];
    end
    return {r, q};
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/sky_keyframe_interpolator_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel  Direction  Handshake             Payload
// in_      request    in_valid / in_stall    in_data  (day ratio, far clip, height)
// out_     result     out_valid / out_stall  out_data (colors, fog, layers, tint)
// cfg_     register   cfg_we                 cfg_data (daytime fog color)
//
// One request enters per cycle while in_stall is low. The pipe holds the blend factor
// divider (two quotient bits per stage, eight stages) and the fog distance multiply and
// reciprocal stages.
// Reset clears the stage valid bits and the fog color register to zero.
// A stage holds while the one after it is full and held; empty stages fill
// even while a result waits on out_stall.

module sky_keyframe_interpolator_unit #(
  parameter int NUM_KEYFRAMES = skyki_pkg::KF_NUM
) (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   in_valid,
  output logic                  in_stall,
  input  skyki_pkg::in_req_t    in_data,
  output logic                  out_valid,
  input  wire                   out_stall,
  output skyki_pkg::out_req_t   out_data,
  input  wire                   cfg_we,
  input  wire  [23:0]           cfg_data
);
  import skyki_pkg::*;

  localparam int NDIV  = 8;
  localparam int S_A   = 0;
  localparam int S_B   = 1;
  localparam int S_C   = 2;
  localparam int S_D0  = 3;
  localparam int S_E   = S_D0 + NDIV;
  localparam int S_F   = S_E + 1;
  localparam int S_G   = S_F + 1;
  localparam int S_H   = S_G + 1;
  localparam int S_I   = S_H + 1;
  localparam int S_O   = S_I + 1;
  localparam int NSTG  = S_O + 1;
  localparam logic [KF_SLOT_W-1:0] LAST = KF_SLOT_W'(NUM_KEYFRAMES - 1);

  // Daytime fog color register.
  logic [23:0] cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      cfg_r <= cfg_data;
    end
  end

  // Stage valid bits and per-stage enables; a stage loads when empty or draining.
  logic [NSTG-1:0] vld_r;
  logic [NSTG-1:0] en;

  always_comb begin
    en[NSTG-1] = !vld_r[NSTG-1] || !out_stall;
    for (int i = NSTG - 2; i >= 0; i--) begin
      en[i] = !vld_r[i] || en[i+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (en[0]) begin
        vld_r[0] <= in_valid;
      end
      for (int i = 1; i < NSTG; i++) begin
        if (en[i]) begin
          vld_r[i] <= vld_r[i-1];
        end
      end
    end
  end

  assign in_stall  = !en[0];
  assign out_valid = vld_r[S_O];

  // Stage A: time of day and search for the enclosing keyframe pair.
  logic [15:0]          t_nxt;
  logic [KF_SLOT_W-1:0] p1_nxt, p2_nxt;
  logic                 found;
  logic [15:0]          t_a_r;
  logic [23:0]          far_a_r;
  logic signed [23:0]   h_a_r;
  logic [KF_SLOT_W-1:0] p1_a_r, p2_a_r;

  always_comb begin
    t_nxt  = in_data.day_ratio + T_HALF;
    p1_nxt = LAST;
    p2_nxt = '0;
    found  = 1'b0;
    for (int i = 1; i < NUM_KEYFRAMES; i++) begin
      if (!found && t_nxt < kf_rom(KF_SLOT_W'(i)).time_q) begin
        p1_nxt = KF_SLOT_W'(i - 1);
        p2_nxt = KF_SLOT_W'(i);
        found  = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[S_A]) begin
      t_a_r   <= t_nxt;
      far_a_r <= in_data.far_clip;
      h_a_r   <= in_data.camera_height;
      p1_a_r  <= p1_nxt;
      p2_a_r  <= p2_nxt;
    end
  end

  // Stage B: registered keyframe table read at both pair addresses.
  kf_t                kf1_b_r, kf2_b_r;
  kf_t                kf1_rd, kf2_rd;
  logic [15:0]        t_b_r;
  logic [23:0]        far_b_r;
  logic signed [23:0] h_b_r;
  logic [2:0]         lk_b_r;

  always_comb begin
    kf1_rd = kf_rom(p1_a_r);
    kf2_rd = kf_rom(p2_a_r);
    if (kf1_rd.fog_from_reg) begin
      kf1_rd.fog = cfg_r;
    end
    if (kf2_rd.fog_from_reg) begin
      kf2_rd.fog = cfg_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en[S_B]) begin
      kf1_b_r <= kf1_rd;
      kf2_b_r <= kf2_rd;
      t_b_r   <= t_a_r;
      far_b_r <= far_a_r;
      h_b_r   <= h_a_r;
      lk_b_r  <= p1_a_r[2:0];
    end
  end

  // Stage C: span and offset of the pair, height-based fog scale, tint band.
  logic [16:0]        end_c, span_nxt_c, num_nxt_c, sh_nxt_c;
  logic signed [23:0] hd_c;
  logic [31:0]        hprod_c;
  logic [16:0]        num_c_r, span_c_r;
  carry_t             car_c_r;

  always_comb begin
    end_c = (kf2_b_r.time_q < kf1_b_r.time_q) ? ({1'b0, kf2_b_r.time_q} + ONE_Q16)
                                              : {1'b0, kf2_b_r.time_q};
    span_nxt_c = (end_c > {1'b0, kf1_b_r.time_q}) ? (end_c - {1'b0, kf1_b_r.time_q}) : '0;
    num_nxt_c  = (t_b_r > kf1_b_r.time_q) ? {1'b0, t_b_r - kf1_b_r.time_q} : '0;
    hd_c       = h_b_r - H_LO;
    hprod_c    = {19'd0, hd_c[12:0]} * {13'd0, RECIP5};
    if (h_b_r <= H_LO) begin
      sh_nxt_c = '0;
    end else if (h_b_r >= H_HI) begin
      sh_nxt_c = ONE_Q16;
    end else begin
      sh_nxt_c = hprod_c[31:15];
    end
  end

  always_ff @(posedge clk) begin
    if (en[S_C]) begin
      num_c_r           <= num_nxt_c;
      span_c_r          <= span_nxt_c;
      car_c_r.kf1       <= kf1_b_r;
      car_c_r.kf2       <= kf2_b_r;
      car_c_r.far_clip  <= far_b_r;
      car_c_r.s_h       <= sh_nxt_c;
      car_c_r.day_band  <= (t_b_r >= T_DAY_START) && (t_b_r <= T_DAY_END);
      car_c_r.layer     <= lk_b_r;
    end
  end

  // Stages D: blend factor divider, two quotient bits per stage.
  logic [16:0] rem_r  [NDIV];
  logic [15:0] q_r    [NDIV];
  logic [16:0] span_r [NDIV];
  carry_t      car_r  [NDIV];
  logic [18:0] dstep  [NDIV];

  always_comb begin
    dstep[0] = div_step2(num_c_r, span_c_r);
    for (int j = 1; j < NDIV; j++) begin
      dstep[j] = div_step2(rem_r[j-1], span_r[j-1]);
    end
  end

  always_ff @(posedge clk) begin
    if (en[S_D0]) begin
      rem_r[0]  <= dstep[0][18:2];
      q_r[0]    <= {14'd0, dstep[0][1:0]};
      span_r[0] <= span_c_r;
      car_r[0]  <= car_c_r;
    end
    for (int j = 1; j < NDIV; j++) begin
      if (en[S_D0+j]) begin
        rem_r[j]  <= dstep[j][18:2];
        q_r[j]    <= {q_r[j-1][13:0], dstep[j][1:0]};
        span_r[j] <= span_r[j-1];
        car_r[j]  <= car_r[j-1];
      end
    end
  end

  // Stage E: blends between the pair.
  logic [15:0] f_e;
  carry_t      cd;
  out_req_t    o_e_nxt;
  logic [23:0] fogc_e_r;
  logic [23:0] far_e_r;
  logic [16:0] sh_e_r;
  out_req_t    o_e_r;

  always_comb begin
    cd = car_r[NDIV-1];
    f_e = (span_r[NDIV-1] == '0) ? '0 : q_r[NDIV-1];
    o_e_nxt                = '0;
    o_e_nxt.base_color_rgb = blend_rgb(cd.kf1.base, cd.kf2.base, f_e);
    o_e_nxt.dome_color_rgb = blend_rgb(cd.kf1.dome, cd.kf2.dome, f_e);
    o_e_nxt.fog_distance   = sat16(blend({1'b0, cd.kf1.fog_dist}, {1'b0, cd.kf2.fog_dist},
                                         f_e));
    o_e_nxt.cloud_alpha    = sat16(blend(cd.kf1.cloud_alpha, cd.kf2.cloud_alpha, f_e));
    o_e_nxt.sky_alpha      = sat16(blend(cd.kf1.sky_alpha, cd.kf2.sky_alpha, f_e));
    o_e_nxt.cloud_scale    = 11'(blend({6'd0, cd.kf1.cloud_scale}, {6'd0, cd.kf2.cloud_scale},
                                       f_e));
    o_e_nxt.sky_scale      = 11'(blend({6'd0, cd.kf1.sky_scale}, {6'd0, cd.kf2.sky_scale},
                                       f_e));
    o_e_nxt.layer_keyframe = cd.layer;
    o_e_nxt.cloud_tint_rgb = cd.day_band ? RGB_WHITE : o_e_nxt.dome_color_rgb;
  end

  always_ff @(posedge clk) begin
    if (en[S_E]) begin
      o_e_r    <= o_e_nxt;
      fogc_e_r <= blend_rgb(cd.kf1.fog, cd.kf2.fog, f_e);
      far_e_r  <= cd.far_clip;
      sh_e_r   <= cd.s_h;
    end
  end

  // Stage F: final fog scale, red intensity and distance multiplier.
  logic [16:0] s_f;
  logic [15:0] k_f_r;
  logic [7:0]  inten_f_r;
  logic [18:0] m_f_r;
  logic [23:0] fogc_f_r, far_f_r;
  out_req_t    o_f_r;

  always_comb begin
    s_f = ({1'b0, o_e_r.fog_distance} > sh_e_r) ? {1'b0, o_e_r.fog_distance} : sh_e_r;
  end

  always_ff @(posedge clk) begin
    if (en[S_F]) begin
      k_f_r     <= s_f[16:1];
      inten_f_r <= (fogc_e_r[23:16] > INTEN_CAP) ? INTEN_CAP : fogc_e_r[23:16];
      m_f_r     <= 19'd131072 + 19'd3 * ({2'b00, ONE_Q16} - {2'b00, s_f});
      fogc_f_r  <= fogc_e_r;
      far_f_r   <= far_e_r;
      o_f_r     <= o_e_r;
    end
  end

  // Stage G: fog color pulled toward the intensity, far clip times multiplier.
  logic [42:0] prod_g_r;
  out_req_t    o_g_nxt;
  out_req_t    o_g_r;

  always_comb begin
    o_g_nxt               = o_f_r;
    o_g_nxt.fog_color_rgb = {blend8(fogc_f_r[23:16], inten_f_r, k_f_r),
                             blend8(fogc_f_r[15:8], inten_f_r, k_f_r),
                             blend8(fogc_f_r[7:0], inten_f_r, k_f_r)};
  end

  always_ff @(posedge clk) begin
    if (en[S_G]) begin
      o_g_r    <= o_g_nxt;
      prod_g_r <= {19'd0, far_f_r} * {24'd0, m_f_r};
    end
  end

  // Stage H: rounding offset and the power-of-two part of both divisions.
  logic [43:0] xfar_h;
  logic [44:0] xnear_h;
  logic [27:0] yfar_h_r, ynear_h_r;
  out_req_t    o_h_r;

  always_comb begin
    xfar_h  = {prod_g_r, 1'b0} + FAR_BIAS;
    xnear_h = {2'b00, prod_g_r} + {1'b0, prod_g_r, 1'b0} + NEAR_BIAS;
  end

  always_ff @(posedge clk) begin
    if (en[S_H]) begin
      yfar_h_r  <= xfar_h[43:16];
      ynear_h_r <= xnear_h[44:17];
      o_h_r     <= o_g_r;
    end
  end

  // Stage I: division by 25 and by 125 through reciprocals.
  logic [56:0] qfar_i;
  logic [55:0] qnear_i;
  logic [23:0] far_i_r;
  logic [21:0] near_i_r;
  out_req_t    o_i_r;

  always_comb begin
    qfar_i  = {29'd0, yfar_h_r} * {28'd0, RECIP25};
    qnear_i = {28'd0, ynear_h_r} * {28'd0, RECIP125};
  end

  always_ff @(posedge clk) begin
    if (en[S_I]) begin
      far_i_r  <= qfar_i[56:33];
      near_i_r <= qnear_i[55:34];
      o_i_r    <= o_h_r;
    end
  end

  // Stage O: result register.
  out_req_t o_o_nxt;
  out_req_t o_o_r;

  always_comb begin
    o_o_nxt          = o_i_r;
    o_o_nxt.fog_far  = far_i_r;
    o_o_nxt.fog_near = {2'b00, near_i_r};
  end

  always_ff @(posedge clk) begin
    if (en[S_O]) begin
      o_o_r <= o_o_nxt;
    end
  end

  assign out_data = o_o_r;

  // The far fog distance never falls below the near one.
  a_far_ge_near: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.fog_far >= out_data.fog_near))
    else $error("fog_far below fog_near");

  // Layer scales stay within the keyframe range.
  a_scale_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.cloud_scale <= 11'd1024 && out_data.sky_scale <= 11'd1024))
    else $error("layer scale out of range");

  // A set day band flag moves with its request from the first divider stage to the second.
  a_tint_day: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r[S_D0] && en[S_D0+1] && car_r[0].day_band) |=> (car_r[1].day_band))
    else $error("tint band lost in divider");

  // Nothing leaves the pipe right after reset.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

`default_nettype wire
